>>> src/rrev_pkg.sv
// Shared widths, codes, payload types and reset values for the rev rate block.
package rrev_pkg;

	localparam int CountW = 16;
	localparam int CoefW  = 24;
	localparam int RateW  = CoefW + CountW;

	localparam int CfgIdxW = 1;

	localparam logic [CfgIdxW-1:0] CFG_SPEED_COEF   = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_CADENCE_COEF = 1'b1;

	localparam logic [CoefW-1:0] SPEED_COEF_RESET   = 24'd7630;
	localparam logic [CoefW-1:0] CADENCE_COEF_RESET = 24'd61440;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic SENSOR_SPEED   = 1'b0;
	localparam logic SENSOR_CADENCE = 1'b1;

	typedef struct packed {
		logic              command;
		logic              sensor;
		logic [CountW-1:0] rev_count;
		logic [CountW-1:0] event_time;
	} sample_t;

	typedef struct packed {
		logic [RateW-1:0] rate;
		logic             updated;
		logic             zero_time_error;
	} result_t;

	// divider handshake, top to divider
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	// divider status, divider to top
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> src/rrev_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface rrev_stream_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/rrev_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module rrev_divider #(
	parameter int DvdW = rrev_pkg::RateW,
	parameter int DsrW = rrev_pkg::CountW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrev_pkg::div_ctrl_t ctrl,
	input  logic [DvdW-1:0]     dividend,
	input  logic [DsrW-1:0]     divisor,
	output rrev_pkg::div_stat_t stat,
	output logic [DvdW-1:0]     quotient
);
	import rrev_pkg::*;

	localparam int CntW = $clog2(DvdW + 1);

	logic [DvdW-1:0] dvd_q;
	logic [DsrW-1:0] dsr_q;
	logic [DsrW-1:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DsrW:0]   trial;
	logic [DsrW:0]   diff;
	logic            fits;

	// remainder stays below divisor, so trial < 2*divisor
	assign trial = {rem_q, dvd_q[DvdW-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse after the last iteration
			done_q <= busy_q && !ctrl.start && (cnt_q == CntW'(1));
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DvdW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DvdW-2:0], fits};
			rem_q <= fits ? diff[DsrW-1:0] : trial[DsrW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

>>> src/rev_rate_from_event_deltas_core.sv
// Top level: per-sensor revolution rate from count and event time deltas.
//
//  channel   dir  payload                                        beat when
//  sample    in   command, sensor, rev_count, event_time         valid & ready
//  result    out  rate, updated, zero_time_error                 valid & ready
//  cfg       in   cfg_idx, cfg_wdata (speed / cadence coef)      cfg_we
//
// A sample that needs a new rate passes, from its beat until the next
// sample can be taken, through the evaluate state, the divider load, the
// divider iterations (one quotient bit each), a writeback and an output load.
// Clear, unchanged-count and zero-time-delta samples skip the divider.
// sample.ready is high only while the sequencer is idle; the result register
// decouples the output, so a stalled result does not block the next sample
// until its own result is ready to load. Reset is asynchronous: per-sensor
// counts, times and held rates go to zero, coefficients to their defaults.
module rev_rate_from_event_deltas_core (
	input  logic                          clk,
	input  logic                          arst_n,
	rrev_stream_if.sink                   sample,
	rrev_stream_if.source                 result,
	input  logic                          cfg_we,
	input  logic [rrev_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [rrev_pkg::CoefW-1:0]    cfg_wdata
);
	import rrev_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [CoefW-1:0] speed_coef_q;
	logic [CoefW-1:0] cadence_coef_q;

	// per-sensor history
	logic [CountW-1:0] last_cnt_q  [2];
	logic [CountW-1:0] last_time_q [2];
	logic [RateW-1:0]  held_rate_q [2];

	// current sample and datapath registers
	sample_t           item_q;
	logic [RateW-1:0]  product_q;
	logic [CountW-1:0] dt_q;
	logic              upd_q;
	logic              err_q;
	logic              div_start_q;

	// output register
	logic              out_valid_q;
	result_t           out_data_q;

	// evaluate-stage combinational values
	logic [CountW-1:0] last_cnt;
	logic [CountW-1:0] dr;
	logic [CountW-1:0] dt;
	logic [CoefW-1:0]  coef;
	logic [RateW-1:0]  coef_x;
	logic [RateW-1:0]  dr_x;
	logic [RateW-1:0]  product;
	logic              cnt_same;
	logic              accept;
	logic              out_free;

	div_ctrl_t         div_ctrl;
	div_stat_t         div_stat;
	logic [RateW-1:0]  quotient;

	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	// deltas wrap modulo 2^16, which covers counter and timer rollover
	assign last_cnt = last_cnt_q[item_q.sensor];
	assign dr       = item_q.rev_count - last_cnt;
	assign dt       = item_q.event_time - last_time_q[item_q.sensor];
	assign cnt_same = item_q.rev_count == last_cnt;
	assign coef     = (item_q.sensor == SENSOR_CADENCE) ? cadence_coef_q : speed_coef_q;

	// 24x16 product, exact in 40 bits; registered before the divide
	assign coef_x  = {{CountW{1'b0}}, coef};
	assign dr_x    = {{CoefW{1'b0}}, dr};
	assign product = coef_x * dr_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_coef_q   <= SPEED_COEF_RESET;
			cadence_coef_q <= CADENCE_COEF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SPEED_COEF:   speed_coef_q   <= cfg_wdata;
				CFG_CADENCE_COEF: cadence_coef_q <= cfg_wdata;
			endcase
		end
	end

	// sequencer and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			last_cnt_q[0]  <= '0;
			last_cnt_q[1]  <= '0;
			last_time_q[0] <= '0;
			last_time_q[1] <= '0;
			held_rate_q[0] <= '0;
			held_rate_q[1] <= '0;
			div_start_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// one-cycle kick for a sample whose count and time both moved
			div_start_q <= (state_q == ST_EVAL) && (item_q.command == CMD_SAMPLE) &&
				!cnt_same && (dt != '0);
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (item_q.command == CMD_CLEAR) begin
						last_cnt_q[0]  <= '0;
						last_cnt_q[1]  <= '0;
						last_time_q[0] <= '0;
						last_time_q[1] <= '0;
						state_q        <= ST_RESP;
					end else if (cnt_same) begin
						state_q <= ST_RESP;
					end else begin
						// new count and time are stored even on a zero time delta
						last_cnt_q[item_q.sensor]  <= item_q.rev_count;
						last_time_q[item_q.sensor] <= item_q.event_time;
						if (dt == '0) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						held_rate_q[item_q.sensor] <= quotient;
						state_q                    <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= sample.data;
		end
		if (state_q == ST_EVAL) begin
			product_q <= product;
			dt_q      <= dt;
			upd_q     <= 1'b0;
			err_q     <= (item_q.command == CMD_SAMPLE) && !cnt_same && (dt == '0);
		end
		if (state_q == ST_DIV && div_stat.done) begin
			upd_q <= 1'b1;
		end
		if (state_q == ST_RESP && out_free) begin
			out_data_q.rate            <= held_rate_q[item_q.sensor];
			out_data_q.updated         <= upd_q;
			out_data_q.zero_time_error <= err_q;
		end
	end

	assign div_ctrl.start = div_start_q;

	rrev_divider #(
		.DvdW (RateW),
		.DsrW (CountW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (product_q),
		.divisor  (dt_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign sample.ready = state_q == ST_IDLE;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider done outside divide state");

	// the divider is never running while the block takes a sample
	a_no_div_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_stat.busy && !div_start_q)
		else $error("sample accepted while divider active");

	// a divide only runs for a real sample
	a_div_only_sample: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> item_q.command == CMD_SAMPLE)
		else $error("divide started for clear command");

	// a result never claims both a new rate and a zero time delta
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.data.updated && result.data.zero_time_error))
		else $error("updated and zero_time_error both set");

endmodule
